// ===== hw/rtl/crcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, result codes and the CRC-16/MODBUS byte update for the
// CRC-checked frame deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

    // Result kind codes carried on tuser
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_CRC_GOOD = 2'd1,
        KIND_CRC_BAD  = 2'd2
    } kind_t;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_FIRST_DELIM  = 2'd0;
    localparam logic [1:0] REG_SECOND_DELIM = 2'd1;
    localparam logic [1:0] REG_MAX_LEN      = 2'd2;

    // Frame layout
    localparam logic [7:0] HEADER_BYTES = 8'd3;
    localparam logic [7:0] FOOTER_BYTES = 8'd2;
    localparam logic [7:0] MIN_FRAME_LEN = HEADER_BYTES + FOOTER_BYTES;

    // CRC-16/MODBUS: reflected poly, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Register reset values
    localparam logic [7:0] MAX_LEN_RESET = 8'd255;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0] first_delimiter;
        logic [7:0] second_delimiter;
        logic [7:0] max_frame_len;
    } cfg_t;

    // One byte through the CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crcdf_regs.sv =====
// ----------------------------------------------------------------------------
// crcdf_regs
// APB register file: delimiter bytes and maximum frame length.
// ----------------------------------------------------------------------------
module crcdf_regs
    import crcdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] first_delim_reg;
    logic [7:0] second_delim_reg;
    logic [7:0] max_len_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delim_reg  <= 8'd0;
            second_delim_reg <= 8'd0;
            max_len_reg      <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FIRST_DELIM:  first_delim_reg  <= pwdata[7:0];
                REG_SECOND_DELIM: second_delim_reg <= pwdata[7:0];
                REG_MAX_LEN:      max_len_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_FIRST_DELIM:  prdata = {24'd0, first_delim_reg};
            REG_SECOND_DELIM: prdata = {24'd0, second_delim_reg};
            REG_MAX_LEN:      prdata = {24'd0, max_len_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.first_delimiter  = first_delim_reg;
    assign cfg.second_delimiter = second_delim_reg;
    assign cfg.max_frame_len    = max_len_reg;

endmodule

// ===== hw/rtl/crcdf_parser.sv =====
// ----------------------------------------------------------------------------
// crcdf_parser
// Frame parser with running CRC, fed from the input register, and the
// result register that drives the output stream.
// ----------------------------------------------------------------------------
module crcdf_parser
    import crcdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_take,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_data,
    output logic [1:0] out_kind,
    output logic       out_last
);

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_LO  = 3'd4,
        PH_CRC_HI  = 3'd5
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [7:0]  seen_reg,      seen_next;
    logic [15:0] crc_reg,       crc_next;
    logic [7:0]  footer_lo_reg, footer_lo_next;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    kind_t       out_kind_reg;
    logic        out_last_reg;

    logic        res_valid;
    logic [7:0]  res_data;
    kind_t       res_kind;
    logic        res_last;
    logic [8:0]  seen_plus_footer;
    logic [15:0] crc_got;

    // Advance when the result register is free or being drained
    assign in_take = in_valid && (!out_valid_reg || out_ready);

    assign seen_plus_footer = {1'b0, seen_reg + 8'd1} + {1'b0, FOOTER_BYTES};
    assign crc_got          = {in_byte, footer_lo_reg};

    // Parse one byte
    always_comb
    begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        seen_next      = seen_reg;
        crc_next       = crc_reg;
        footer_lo_next = footer_lo_reg;
        res_valid      = 1'b0;
        res_data       = 8'd0;
        res_kind       = KIND_PAYLOAD;
        res_last       = 1'b0;

        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (in_byte == cfg.second_delimiter)
                    phase_next = PH_LENGTH;
                else if (in_byte != cfg.first_delimiter)
                    phase_next = PH_HUNT1;
            end
            PH_LENGTH:
            begin
                if (in_byte < MIN_FRAME_LEN || in_byte > cfg.max_frame_len)
                begin
                    // drop frame silently
                    phase_next     = PH_HUNT1;
                    frame_len_next = 8'd0;
                    seen_next      = 8'd0;
                    crc_next       = CRC_INIT;
                    footer_lo_next = 8'd0;
                end
                else
                begin
                    frame_len_next = in_byte;
                    seen_next      = HEADER_BYTES;
                    crc_next       = CRC_INIT;
                    // empty payload goes straight to the footer
                    phase_next     = (in_byte == MIN_FRAME_LEN) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                crc_next  = crc_byte(crc_reg, in_byte);
                seen_next = seen_reg + 8'd1;
                if (seen_plus_footer >= {1'b0, frame_len_reg})
                    phase_next = PH_CRC_LO;
                res_valid = 1'b1;
                res_data  = in_byte;
                res_kind  = KIND_PAYLOAD;
            end
            PH_CRC_LO:
            begin
                footer_lo_next = in_byte;
                seen_next      = seen_reg + 8'd1;
                phase_next     = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                phase_next     = PH_HUNT1;
                frame_len_next = 8'd0;
                seen_next      = 8'd0;
                crc_next       = CRC_INIT;
                footer_lo_next = 8'd0;
                res_valid      = 1'b1;
                res_kind       = (crc_got == crc_reg) ? KIND_CRC_GOOD : KIND_CRC_BAD;
                res_last       = 1'b1;
            end
            default:
            begin
                // first delimiter hunt, also unused codes
                phase_next = (in_byte == cfg.first_delimiter) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            frame_len_reg <= 8'd0;
            seen_reg      <= 8'd0;
            crc_reg       <= CRC_INIT;
            footer_lo_reg <= 8'd0;
        end
        else if (in_take)
        begin
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            seen_reg      <= seen_next;
            crc_reg       <= crc_next;
            footer_lo_reg <= footer_lo_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_take)
            out_valid_reg <= res_valid;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (in_take && res_valid)
        begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    // Status item always carries a CRC verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |->
            (out_kind_reg == KIND_CRC_GOOD || out_kind_reg == KIND_CRC_BAD))
        else $error("status item without CRC verdict");

    // Payload items carry the payload kind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_kind_reg == KIND_PAYLOAD)
        else $error("payload item with status kind");

    // Status items carry a zero data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_data_reg == 8'd0)
        else $error("status item with nonzero data");

    // Closing a frame returns the parser to the hunt
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && res_last |=> phase_reg == PH_HUNT1 && crc_reg == CRC_INIT)
        else $error("parser not restarted after frame end");
`endif

endmodule

// ===== hw/rtl/crc_checked_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer
// Byte-stream deframer: delimiter hunt, length check, payload forwarding and
// CRC-16/MODBUS footer check with an end-of-frame status item.
//
//   channel   dir  handshake            contents
//   s_*       in   s_tvalid/s_tready    tdata: byte_in[7:0]
//   m_*       out  m_tvalid/m_tready    tdata: payload_byte, tuser: kind, tlast: frame_end
//   apb       in   psel/penable/pready  regs 0x0 first, 0x4 second delim, 0x8 max len
//
// One byte per cycle while m_tready stays high; each byte passes an input
// register, the parser and CRC update, and the result register.
// The byte-wide CRC update between the two registers sets the clock path.
// A stall on m_tready holds the result register, and the parser stops with
// the next byte held in the input register; s_tready drops once both are
// full. Asynchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer
    import crcdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] byte_in
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] payload_byte
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast,     // frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_take;

    crcdf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    assign s_tready = !in_valid_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (in_take)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    crcdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .in_take   (in_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the CRC-checked frame deframer. Byte streams of well-formed frames
// with good and bad CRC, dropped lengths, broken headers and line noise are
// sent under several delimiter and length settings. A model of the parser
// built into the bench predicts every payload byte and end-of-frame status.
// Each output request is then checked in order against those predictions,
// with random idling on both sides, a long output stall and a sender pause.
// ----------------------------------------------------------------------------
module testbench;
    import crcdf_pkg::*;

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        READ_LENGTH,
        PAYLOAD_BYTES,
        FOOTER_LOW,
        FOOTER_HIGH
    } parse_phase_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] payload;
        logic       frame_end;
    } deframe_out_t;

    localparam int IDLE_PERCENT   = 18;
    localparam int OUT_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Bytes waiting to be sent, expected output requests
    logic [7:0]   pending_bytes[$];
    deframe_out_t expected_out[$];
    logic [7:0]   payload_buf[$];

    // Register copies and parser state of the predictor
    logic [7:0]   cfg_first = 8'h00;
    logic [7:0]   cfg_second = 8'h00;
    logic [7:0]   cfg_max_len = MAX_LEN_RESET;
    parse_phase_t parse_phase = HUNT_FIRST;
    logic [7:0]   frame_len = 8'h00;
    logic [7:0]   bytes_seen = 8'h00;
    logic [15:0]  crc_acc = CRC_INIT;
    logic [7:0]   footer_lo = 8'h00;

    int error_count = 0;
    bit steady_flow = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    crc_checked_frame_deframer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // CRC-16/MODBUS, one data bit at a time
    function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                      input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c = {1'b0, c[15:1]};
            if (fb)
                c = c ^ 16'hA001;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic restart_hunt();
        parse_phase = HUNT_FIRST;
        frame_len = 8'h00;
        bytes_seen = 8'h00;
        crc_acc = CRC_INIT;
        footer_lo = 8'h00;
    endtask

    // Advance the parser copy by one byte and queue any output it makes
    task automatic predict_byte(input logic [7:0] b);
        deframe_out_t r;
        r.kind = KIND_PAYLOAD;
        r.payload = 8'h00;
        r.frame_end = 1'b0;
        case (parse_phase)
            HUNT_SECOND:
            begin
                if (b == cfg_second)
                    parse_phase = READ_LENGTH;
                else if (b != cfg_first)
                    parse_phase = HUNT_FIRST;
            end
            READ_LENGTH:
            begin
                if (b < MIN_FRAME_LEN || b > cfg_max_len)
                    restart_hunt();
                else
                begin
                    frame_len = b;
                    bytes_seen = HEADER_BYTES;
                    crc_acc = CRC_INIT;
                    parse_phase = (b == MIN_FRAME_LEN) ? FOOTER_LOW : PAYLOAD_BYTES;
                end
            end
            PAYLOAD_BYTES:
            begin
                crc_acc = modbus_crc_update(crc_acc, b);
                bytes_seen = bytes_seen + 8'd1;
                if ({1'b0, bytes_seen} + {1'b0, FOOTER_BYTES} >= {1'b0, frame_len})
                    parse_phase = FOOTER_LOW;
                r.payload = b;
                expected_out.push_back(r);
            end
            FOOTER_LOW:
            begin
                footer_lo = b;
                bytes_seen = bytes_seen + 8'd1;
                parse_phase = FOOTER_HIGH;
            end
            FOOTER_HIGH:
            begin
                r.kind = ({b, footer_lo} == crc_acc) ? KIND_CRC_GOOD : KIND_CRC_BAD;
                r.frame_end = 1'b1;
                restart_hunt();
                expected_out.push_back(r);
            end
            default:
                parse_phase = (b == cfg_first) ? HUNT_SECOND : HUNT_FIRST;
        endcase
    endtask

    // Input side: offer queued bytes, idle at random between requests
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0
                    && (steady_flow || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_bytes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: check each request, idle at random or hold off on demand
    always @(posedge clk)
    begin
        deframe_out_t e;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_out.size() == 0)
                    report_mismatch($sformatf("unexpected output kind=%0d data=%02h last=%0b",
                                              m_tuser, m_tdata, m_tlast));
                else
                begin
                    e = expected_out.pop_front();
                    if (m_tuser !== e.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, e.kind));
                    if (m_tdata !== e.payload)
                        report_mismatch($sformatf("payload %02h, expected %02h",
                                                  m_tdata, e.payload));
                    if (m_tlast !== e.frame_end)
                        report_mismatch($sformatf("frame end %0b, expected %0b",
                                                  m_tlast, e.frame_end));
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served <= holds_served + 1;
                hold_left <= OUT_HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_FIRST_DELIM:  cfg_first = value;
            REG_SECOND_DELIM: cfg_second = value;
            REG_MAX_LEN:      cfg_max_len = value;
            default:          ;
        endcase
    endtask

    task automatic configure(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] max_len);
        write_register(REG_FIRST_DELIM, first);
        write_register(REG_SECOND_DELIM, second);
        write_register(REG_MAX_LEN, max_len);
    endtask

    // Wait until everything sent has come out, then let the pipe settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_out.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Queue a frame with the current delimiters and the bytes in payload_buf
    task automatic push_frame(input logic [7:0] length, input bit corrupt_crc);
        logic [15:0] crc;
        crc = CRC_INIT;
        pending_bytes.push_back(cfg_first);
        pending_bytes.push_back(cfg_second);
        pending_bytes.push_back(length);
        for (int i = 0; i + 5 < length; i++)
        begin
            crc = modbus_crc_update(crc, payload_buf[i]);
            pending_bytes.push_back(payload_buf[i]);
        end
        if (corrupt_crc)
            crc = crc ^ (16'h1 << $urandom_range(15));
        pending_bytes.push_back(crc[7:0]);
        pending_bytes.push_back(crc[15:8]);
    endtask

    // Mostly well-formed frames, the rest dropped lengths, broken headers and noise
    task automatic push_random_traffic(input int count);
        int          goal;
        int          roll;
        int          hi;
        logic [7:0]  len;
        goal = pending_bytes.size() + count;
        while (pending_bytes.size() < goal)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                hi = (cfg_max_len < 5) ? 20 : ((cfg_max_len < 20) ? cfg_max_len : 20);
                if (cfg_max_len >= 5 && $urandom_range(9) == 0)
                    hi = cfg_max_len;
                len = 8'($urandom_range(hi, 5));
                payload_buf.delete();
                for (int i = 0; i + 5 < len; i++)
                    payload_buf.push_back(8'($urandom_range(255)));
                push_frame(len, $urandom_range(4) == 0);
            end
            else if (roll < 80)
            begin
                pending_bytes.push_back(cfg_first);
                pending_bytes.push_back(cfg_second);
                if (cfg_max_len < 255 && $urandom_range(1) == 1)
                    pending_bytes.push_back(8'($urandom_range(255, cfg_max_len + 1)));
                else
                    pending_bytes.push_back(8'($urandom_range(4)));
            end
            else if (roll < 88)
            begin
                pending_bytes.push_back(cfg_first);
                pending_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    pending_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames
        configure(8'h7E, 8'h81, 8'd255);
        payload_buf.delete();
        push_frame(8'd5, 1'b0);                 // empty payload
        payload_buf = '{8'h00, 8'hFF};
        push_frame(8'd7, 1'b1);                 // bad CRC
        pending_bytes.push_back(8'h7E);         // length too short: dropped
        pending_bytes.push_back(8'h81);
        pending_bytes.push_back(8'h04);
        pending_bytes.push_back(8'h7E);         // wrong second byte: hunt restarts
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'h7E);         // repeated first byte: rescanned
        payload_buf = '{8'h80};
        push_frame(8'd6, 1'b0);
        push_random_traffic(300);
        drain();

        // Reset-value settings, no idling on either side
        configure(8'h00, 8'h00, 8'd255);
        steady_flow = 1'b1;
        push_random_traffic(300);
        drain();
        steady_flow = 1'b0;

        // Only empty frames fit; the sender pauses halfway until all is out
        configure(8'hFF, 8'h00, 8'd5);
        push_random_traffic(100);
        drain();
        push_random_traffic(100);
        drain();

        // Every frame dropped
        configure(8'h55, 8'hAA, 8'd0);
        push_random_traffic(40);
        drain();

        // Long output hold while the sender keeps offering
        configure(8'hA5, 8'hFF, 8'd40);
        push_random_traffic(400);
        hold_requests = hold_requests + 1;
        drain();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
